// File: rtl/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types, codes, scale tables and helpers for the grid step sequencer.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int GSS_LAYER_COUNT = 4;
    localparam int GSS_GRID_SIDE   = 4;

    localparam int AXIS_COUNT = 3;
    localparam int CNT_W      = 8;
    localparam int DEG_W      = 8;
    localparam int VEL_W      = 7;
    localparam int NOTE_W     = 7;
    localparam int SPAN_W     = 7;
    localparam int MAG_W      = 9;
    localparam int STEP_W     = $clog2(MAG_W);
    localparam int NOTE_MAX   = 127;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_NUDGE = 2'd2;

    // pitch modes
    localparam logic [2:0] MODE_RANGE  = 3'd0;
    localparam logic [2:0] MODE_MAJOR  = 3'd1;
    localparam logic [2:0] MODE_MINOR  = 3'd2;
    localparam logic [2:0] MODE_DORIAN = 3'd3;
    localparam logic [2:0] MODE_PENTA  = 3'd4;
    localparam logic [2:0] MODE_CHROM  = 3'd5;

    // register indexes
    localparam logic [2:0] REG_PITCH_MODE  = 3'd0;
    localparam logic [2:0] REG_RANGE       = 3'd1;
    localparam logic [2:0] REG_MIN_DEGREE  = 3'd2;
    localparam logic [2:0] REG_ROOT_NOTE   = 3'd3;
    localparam logic [2:0] REG_Z_ENABLE    = 3'd4;
    localparam logic [2:0] REG_LAYER       = 3'd5;
    localparam logic [2:0] REG_DIVISIONS   = 3'd6;
    localparam logic [2:0] REG_DIRECTIONS  = 3'd7;

    localparam logic [2:0]  RST_PITCH_MODE = 3'd1;
    localparam logic [6:0]  RST_RANGE      = 7'd12;
    localparam logic [6:0]  RST_ROOT_NOTE  = 7'd60;
    localparam logic [23:0] RST_DIVISIONS  = 24'h100401;

    localparam logic [3:0] SC_MAJOR  [7] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11};
    localparam logic [3:0] SC_MINOR  [7] = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10};
    localparam logic [3:0] SC_DORIAN [7] = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10};
    localparam logic [3:0] SC_PENTA  [5] = '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9};

    typedef struct packed {
        logic             gate;
        logic [DEG_W-1:0] degree;
        logic [VEL_W-1:0] velocity;
    } cell_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_LOOKUP,
        ST_LOAD,
        ST_DIV,
        ST_FIX,
        ST_FINISH
    } seq_state_t;

    function automatic logic [SPAN_W-1:0] scale_len(input logic [2:0] mode);
        case (mode)
            MODE_PENTA: scale_len = SPAN_W'(5);
            MODE_CHROM: scale_len = SPAN_W'(12);
            default:    scale_len = SPAN_W'(7);
        endcase
    endfunction

    function automatic logic [3:0] scale_note(input logic [2:0] mode, input logic [3:0] idx);
        case (mode)
            MODE_MINOR:  scale_note = SC_MINOR[idx[2:0]];
            MODE_DORIAN: scale_note = SC_DORIAN[idx[2:0]];
            MODE_PENTA:  scale_note = SC_PENTA[idx[2:0]];
            MODE_CHROM:  scale_note = idx;
            default:     scale_note = SC_MAJOR[idx[2:0]];
        endcase
    endfunction

    // small remainder of a two-bit value
    function automatic logic [1:0] reduce_small(input logic [1:0] v, input logic [4:0] m);
        logic [1:0] r;
        r = v;
        for (int i = 0; i < 3; i++)
        begin
            if ({3'b000, r} >= m)
            begin
                r = r - m[1:0];
            end
        end
        reduce_small = r;
    endfunction

endpackage

// File: rtl/gss_if.sv
// ----------------------------------------------------------------------------
// gss_cmd_if / gss_res_if
// Valid/ready channels for sequencer commands and tick results.
// ----------------------------------------------------------------------------
interface gss_cmd_if
    import gss_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              func;
    logic [1:0]              cell_layer;
    logic [1:0]              cell_x;
    logic [1:0]              cell_y;
    logic                    gate_in;
    logic signed [DEG_W-1:0] degree_in;
    logic [VEL_W-1:0]        velocity_in;
    logic signed [DEG_W-1:0] nudge_amount;
    logic                    root_active;

    modport source (
        output valid, func, cell_layer, cell_x, cell_y, gate_in, degree_in,
               velocity_in, nudge_amount, root_active,
        input  ready
    );
    modport sink (
        input  valid, func, cell_layer, cell_x, cell_y, gate_in, degree_in,
               velocity_in, nudge_amount, root_active,
        output ready
    );
endinterface

interface gss_res_if
    import gss_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        pos_x;
    logic [1:0]        pos_y;
    logic [1:0]        pos_z;
    logic              fired;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity_out;

    modport source (
        output valid, pos_x, pos_y, pos_z, fired, note, velocity_out,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, fired, note, velocity_out,
        output ready
    );
endinterface

// File: rtl/grid_step_sequencer_tick_top.sv
// ----------------------------------------------------------------------------
// grid_step_sequencer_tick_top
// Grid step sequencer: playhead axes, cell store and scale quantizer.
// ----------------------------------------------------------------------------
// write: taken in the transfer cycle
// tick: steps through ST_AXIS, ST_LOOKUP, ST_LOAD, ST_DIV and ST_FIX (skipped when the cell does not fire), ST_FINISH
// tick: next command taken in the cycle after the result loads, later while it waits
// nudge: the remainder unit takes one bit per cycle over 9 bits
// a new command is taken only while the sequencer is idle
// async active-low reset: registers to defaults, cell store reads empty
module grid_step_sequencer_tick_top
    import gss_pkg::*;
#(
    parameter int LAYER_COUNT = GSS_LAYER_COUNT,
    parameter int GRID_SIDE   = GSS_GRID_SIDE
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    gss_cmd_if.sink            cmd,
    gss_res_if.source          res
);

    localparam int DEPTH = LAYER_COUNT * GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(GRID_SIDE);

    // configuration registers
    logic [2:0]        pitch_mode_reg;
    logic [6:0]        range_reg;
    logic [6:0]        min_degree_reg;
    logic [6:0]        root_note_reg;
    logic              z_enable_reg;
    logic [1:0]        active_layer_reg;
    logic [23:0]       axis_div_reg;
    logic [5:0]        axis_dir_reg;

    seq_state_t        state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg  [AXIS_COUNT];
    logic [CNT_W-1:0]  cnt_next [AXIS_COUNT];
    logic [PW-1:0]     pos_reg  [AXIS_COUNT];
    logic [PW-1:0]     pos_next [AXIS_COUNT];

    cell_t             mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    cell_t             rd_data_reg;
    logic              rd_valid_reg;

    logic [AW-1:0]     addr_reg;
    logic              is_nudge_reg;
    logic              root_active_reg;
    logic [DEG_W-1:0]  nudge_reg;
    cell_t             cell_reg;
    logic              fire_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [SPAN_W-1:0] rem_reg;
    logic [SPAN_W-1:0] span_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_cnt_reg;

    logic              res_valid_reg, res_valid_next;
    logic [1:0]        res_pos_x_reg;
    logic [1:0]        res_pos_y_reg;
    logic [1:0]        res_pos_z_reg;
    logic              res_fired_reg;
    logic [NOTE_W-1:0] res_note_reg;
    logic [VEL_W-1:0]  res_vel_reg;

    logic              cfg_we;
    logic              cmd_ready;
    logic              cmd_fire;
    logic              res_load;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    cell_t             mem_wdata;

    logic [AW-1:0]     cmd_addr;
    logic [AW-1:0]     tick_addr;
    logic [1:0]        play_layer;
    cell_t             cell_rd;
    logic              fire_now;
    logic signed [MAG_W-1:0] load_val;
    logic [SPAN_W-1:0] span_cur;
    logic [SPAN_W:0]   trial;
    logic [SPAN_W-1:0] rem_step;
    logic [DEG_W-1:0]  mapped;
    logic [NOTE_W+1:0] note_sum;
    logic [NOTE_W-1:0] note_clamped;

    function automatic logic [AW-1:0] cell_addr(
        input logic [1:0]    layer,
        input logic [PW-1:0] col,
        input logic [PW-1:0] row
    );
        cell_addr = AW'((int'(layer) * GRID_SIDE + int'(row)) * GRID_SIDE + int'(col));
    endfunction

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_mode_reg   <= RST_PITCH_MODE;
            range_reg        <= RST_RANGE;
            min_degree_reg   <= '0;
            root_note_reg    <= RST_ROOT_NOTE;
            z_enable_reg     <= 1'b0;
            active_layer_reg <= '0;
            axis_div_reg     <= RST_DIVISIONS;
            axis_dir_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                REG_PITCH_MODE: pitch_mode_reg   <= pwdata[2:0];
                REG_RANGE:      range_reg        <= pwdata[6:0];
                REG_MIN_DEGREE: min_degree_reg   <= pwdata[6:0];
                REG_ROOT_NOTE:  root_note_reg    <= pwdata[6:0];
                REG_Z_ENABLE:   z_enable_reg     <= pwdata[0];
                REG_LAYER:      active_layer_reg <= pwdata[1:0];
                REG_DIVISIONS:  axis_div_reg     <= pwdata[23:0];
                REG_DIRECTIONS: axis_dir_reg     <= pwdata[5:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_PITCH_MODE: prdata = PDATA_W'(pitch_mode_reg);
            REG_RANGE:      prdata = PDATA_W'(range_reg);
            REG_MIN_DEGREE: prdata = PDATA_W'(min_degree_reg);
            REG_ROOT_NOTE:  prdata = PDATA_W'(root_note_reg);
            REG_Z_ENABLE:   prdata = PDATA_W'(z_enable_reg);
            REG_LAYER:      prdata = PDATA_W'(active_layer_reg);
            REG_DIVISIONS:  prdata = PDATA_W'(axis_div_reg);
            REG_DIRECTIONS: prdata = PDATA_W'(axis_dir_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // addressing and playhead axes
    // ------------------------------------------------------------------
    assign cmd_addr = cell_addr(
        reduce_small(cmd.cell_layer, 5'(LAYER_COUNT)),
        PW'(reduce_small(cmd.cell_x, 5'(GRID_SIDE))),
        PW'(reduce_small(cmd.cell_y, 5'(GRID_SIDE))));

    assign play_layer = reduce_small(active_layer_reg, 5'(LAYER_COUNT));
    assign tick_addr  = cell_addr(play_layer, pos_next[0], pos_next[1]);

    always_comb
    begin
        logic [CNT_W-1:0] div;
        logic [CNT_W:0]   inc;
        logic [1:0]       dir;
        for (int a = 0; a < AXIS_COUNT; a++)
        begin
            div = axis_div_reg[CNT_W*a +: CNT_W];
            dir = axis_dir_reg[2*a +: 2];
            if (div == '0)
            begin
                div = CNT_W'(1);
            end
            inc         = {1'b0, cnt_reg[a]} + (CNT_W+1)'(1);
            cnt_next[a] = cnt_reg[a];
            pos_next[a] = pos_reg[a];
            if ((a != 2) || z_enable_reg)
            begin
                cnt_next[a] = inc[CNT_W-1:0];
                if (inc >= {1'b0, div})
                begin
                    cnt_next[a] = CNT_W'(inc - {1'b0, div});
                    if (dir[0] ^ dir[1])
                    begin
                        pos_next[a] = (pos_reg[a] == '0) ? PW'(GRID_SIDE - 1)
                                                         : pos_reg[a] - PW'(1);
                    end
                    else
                    begin
                        pos_next[a] = (pos_reg[a] >= PW'(GRID_SIDE - 1)) ? '0
                                                         : pos_reg[a] + PW'(1);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign cell_rd  = rd_valid_reg ? rd_data_reg : '0;
    assign fire_now = cell_rd.gate && root_active_reg;
    assign span_cur = (pitch_mode_reg == MODE_RANGE)
                    ? ((range_reg == '0) ? SPAN_W'(1) : range_reg)
                    : scale_len(pitch_mode_reg);
    assign load_val = is_nudge_reg
                    ? ($signed({cell_rd.degree[DEG_W-1], cell_rd.degree})
                       + $signed({nudge_reg[DEG_W-1], nudge_reg}))
                    : $signed({cell_rd.degree[DEG_W-1], cell_rd.degree});

    // shared remainder step
    assign trial    = {rem_reg, mag_reg[MAG_W-1]};
    assign rem_step = (trial >= {1'b0, span_reg}) ? SPAN_W'(trial - {1'b0, span_reg})
                                                  : trial[SPAN_W-1:0];

    assign mapped = (pitch_mode_reg == MODE_RANGE)
                  ? ({1'b0, min_degree_reg} + {1'b0, rem_reg})
                  : DEG_W'(scale_note(pitch_mode_reg, rem_reg[3:0]));
    assign note_sum     = {2'b00, root_note_reg} + {1'b0, mapped};
    assign note_clamped = (note_sum > (NOTE_W+2)'(NOTE_MAX)) ? NOTE_W'(NOTE_MAX)
                                                             : note_sum[NOTE_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.func == FUNC_TICK))
                begin
                    state_next = ST_AXIS;
                end
                else if (cmd_fire && (cmd.func == FUNC_NUDGE))
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_AXIS:   state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_LOAD;
            ST_LOAD:   state_next = (is_nudge_reg || fire_now) ? ST_DIV : ST_FINISH;
            ST_DIV:    state_next = (step_cnt_reg == '0) ? ST_FIX : ST_DIV;
            ST_FIX:    state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (is_nudge_reg || res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready = 1'b0;
        res_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '{gate: cell_reg.gate, degree: {1'b0, rem_reg},
                      velocity: cell_reg.velocity};
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd.valid && (cmd.func == FUNC_WRITE))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cmd_addr;
                    mem_wdata = '{gate: cmd.gate_in, degree: cmd.degree_in,
                                  velocity: cmd.velocity_in};
                end
            end
            ST_FINISH:
            begin
                mem_we   = is_nudge_reg;
                res_load = !is_nudge_reg && (!res_valid_reg || res.ready);
            end
            default: ;
        endcase
    end

    assign cmd_fire  = cmd.valid && cmd_ready;
    assign cmd.ready = cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                cnt_reg[a] <= '0;
                pos_reg[a] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            if (state_reg == ST_AXIS)
            begin
                cnt_reg <= cnt_next;
                pos_reg <= pos_next;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // cell store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg  <= mem[addr_reg];
        rd_valid_reg <= valid_reg[addr_reg];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            addr_reg        <= cmd_addr;
            is_nudge_reg    <= (cmd.func == FUNC_NUDGE);
            root_active_reg <= cmd.root_active;
            nudge_reg       <= cmd.nudge_amount;
        end
        case (state_reg)
            ST_AXIS:
            begin
                addr_reg <= tick_addr;
            end
            ST_LOAD:
            begin
                cell_reg     <= cell_rd;
                fire_reg     <= fire_now;
                span_reg     <= span_cur;
                neg_reg      <= load_val[MAG_W-1];
                mag_reg      <= load_val[MAG_W-1] ? MAG_W'(-load_val) : MAG_W'(load_val);
                rem_reg      <= '0;
                step_cnt_reg <= STEP_W'(MAG_W - 1);
            end
            ST_DIV:
            begin
                rem_reg      <= rem_step;
                mag_reg      <= mag_reg << 1;
                step_cnt_reg <= step_cnt_reg - STEP_W'(1);
            end
            ST_FIX:
            begin
                if (neg_reg && (rem_reg != '0))
                begin
                    rem_reg <= span_reg - rem_reg;
                end
            end
            default: ;
        endcase
        if (res_load)
        begin
            res_pos_x_reg <= 2'(pos_reg[0]);
            res_pos_y_reg <= 2'(pos_reg[1]);
            res_pos_z_reg <= z_enable_reg ? 2'(pos_reg[2]) : active_layer_reg;
            res_fired_reg <= fire_reg;
            res_note_reg  <= fire_reg ? note_clamped : '0;
            res_vel_reg   <= fire_reg ? cell_reg.velocity : '0;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.pos_x        = res_pos_x_reg;
    assign res.pos_y        = res_pos_y_reg;
    assign res.pos_z        = res_pos_z_reg;
    assign res.fired        = res_fired_reg;
    assign res.note         = res_note_reg;
    assign res.velocity_out = res_vel_reg;

endmodule
